>>> rtl/tcp_flow_http_capture_gate_macros.svh
// assertion macros for the capture gate rtl
// used by modules that check their own control logic; expects clk and rst_n in scope
`ifndef TCP_FLOW_HTTP_CAPTURE_GATE_MACROS_SVH
`define TCP_FLOW_HTTP_CAPTURE_GATE_MACROS_SVH

// same-cycle implication
`define TFHCG_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("capture gate check failed");

// next-cycle implication
`define TFHCG_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("capture gate check failed");

`endif

>>> rtl/tfhcg_pkg.sv
// shared types, constants and the http prefix test for the capture gate
// no dependencies
package tfhcg_pkg;

  localparam int TGT_ENTRIES  = 64;
  localparam int TGT_AW       = $clog2(TGT_ENTRIES);
  localparam int CONN_ENTRIES = 4096;
  localparam int CONN_AW      = $clog2(CONN_ENTRIES);
  localparam int CONN_CW      = CONN_AW + 1;
  localparam int AGE_W        = CONN_AW;
  localparam int TAG_W        = 64;
  localparam int CFG_W        = 23;
  localparam int CFG_IDX_W    = 8;
  localparam int CFG_DATA_W   = 32;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TIER_SMALL  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TIER_MEDIUM = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TIER_LARGE  = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_RECORD  = 8'd3;

  localparam logic [CFG_W-1:0] RST_TIER_SMALL  = 23'd4096;
  localparam logic [CFG_W-1:0] RST_TIER_MEDIUM = 23'd65536;
  localparam logic [CFG_W-1:0] RST_TIER_LARGE  = 23'd1048576;
  localparam logic [CFG_W-1:0] RST_MAX_RECORD  = 23'd4194304;

  typedef enum logic [2:0] {
    V_WRITTEN    = 3'd0,
    V_NOT_TARGET = 3'd1,
    V_EMPTY      = 3'd2,
    V_READ_FAIL  = 3'd3,
    V_NOT_HTTP   = 3'd4,
    V_EMITTED    = 3'd5
  } verdict_t;

  typedef enum logic [1:0] {
    TIER_SMALL  = 2'd0,
    TIER_MEDIUM = 2'd1,
    TIER_LARGE  = 2'd2,
    TIER_MAX    = 2'd3
  } tier_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_TGT,
    ST_CACHE,
    ST_OUT
  } gate_state_t;

  typedef enum logic [1:0] {
    CS_IDLE,
    CS_PROBE,
    CS_DEC,
    CS_UPD
  } cache_state_t;

  typedef struct packed {
    logic wr;
    logic srch;
  } tgt_cmd_t;

  typedef struct packed {
    logic done;
    logic match;
  } tgt_rsp_t;

  typedef struct packed {
    logic start;
    logic http_ok;
  } cache_cmd_t;

  typedef struct packed {
    logic done;
    logic emit;
  } cache_rsp_t;

  // ascii bytes of the prefixes
  localparam logic [7:0] CH_SP = 8'h20;
  localparam logic [7:0] CH_A  = 8'h41;
  localparam logic [7:0] CH_C  = 8'h43;
  localparam logic [7:0] CH_D  = 8'h44;
  localparam logic [7:0] CH_E  = 8'h45;
  localparam logic [7:0] CH_G  = 8'h47;
  localparam logic [7:0] CH_H  = 8'h48;
  localparam logic [7:0] CH_I  = 8'h49;
  localparam logic [7:0] CH_L  = 8'h4C;
  localparam logic [7:0] CH_N  = 8'h4E;
  localparam logic [7:0] CH_O  = 8'h4F;
  localparam logic [7:0] CH_P  = 8'h50;
  localparam logic [7:0] CH_S  = 8'h53;
  localparam logic [7:0] CH_T  = 8'h54;
  localparam logic [7:0] CH_U  = 8'h55;

  // byte 0 sits in bits 7:0
  function automatic logic head4(input logic [31:0] w, input logic [7:0] a,
                                 input logic [7:0] b, input logic [7:0] c,
                                 input logic [7:0] d);
    head4 = (w == {d, c, b, a});
  endfunction

  // method or response prefix within the copied bytes
  function automatic logic looks_http(input logic [47:0] h, input logic [CFG_W-1:0] n);
    logic [31:0] w;
    logic        r;
    w = h[31:0];
    r = head4(w, CH_H, CH_T, CH_T, CH_P) || head4(w, CH_G, CH_E, CH_T, CH_SP) ||
        head4(w, CH_P, CH_O, CH_S, CH_T) || head4(w, CH_P, CH_U, CH_T, CH_SP) ||
        head4(w, CH_H, CH_E, CH_A, CH_D) || head4(w, CH_O, CH_P, CH_T, CH_I) ||
        head4(w, CH_C, CH_O, CH_N, CH_N);
    if ((n >= CFG_W'(6)) && head4(w, CH_D, CH_E, CH_L, CH_E) &&
        (h[39:32] == CH_T) && (h[47:40] == CH_E)) begin
      r = 1'b1;
    end
    if ((n >= CFG_W'(5)) && head4(w, CH_P, CH_A, CH_T, CH_C) && (h[39:32] == CH_H)) begin
      r = 1'b1;
    end
    looks_http = r && (n >= CFG_W'(4));
  endfunction

endpackage

>>> rtl/tcp_flow_http_capture_gate.sv
// tcp flow http capture gate: top level with control sequencer and config registers
// depends on tfhcg_pkg, tfhcg_tgt_table, tfhcg_conn_cache and the macro header
//
// Usage:
//   Items enter on start/busy: an item is taken at a clock edge with start high and
//   busy low. in_func 0 writes a target slot, 1 classifies a segment.
//   Each item gives one result word, shown for one cycle with out_valid high; the
//   receiver must take it then, there is no back pressure.
//   Tier registers are written through cfg_valid/cfg_ready/cfg_index/cfg_data;
//   cfg_ready is always high, writes are meant for idle periods.
//   The steps from the accept edge: a slot write passes the eval and output states.
//   A classify runs a sweep over the 64 target slots; without cache work its result
//   follows in the output state. When the segment needs the cache, a probe sweep
//   over the live cache entries, a decision state and, on a hit or insert, an update
//   sweep follow before the result.
//   One item is handled at a time: busy stays high until the result cycle has
//   passed, so no new item is taken during the target sweep or the cache sweeps.
//   Reset clears the target live bits, empties the cache (fill count zero) and
//   loads the default tier sizes; no clearing pass is needed.
`include "tcp_flow_http_capture_gate_macros.svh"

module tcp_flow_http_capture_gate (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic                                 in_func,
  input  logic [5:0]                           in_slot,
  input  logic                                 in_entry_valid,
  input  logic [31:0]                          in_dest_ip,
  input  logic [15:0]                          in_dest_port,
  input  logic [63:0]                          in_conn_id,
  input  logic [31:0]                          in_payload_len,
  input  logic [47:0]                          in_head_bytes,
  input  logic                                 in_read_ok,
  input  logic                                 in_direction,
  output logic                                 out_valid,
  output logic [2:0]                           out_verdict,
  output logic [1:0]                           out_tier,
  output logic                                 out_truncated,
  output logic [22:0]                          out_cap_len,
  output logic [63:0]                          out_conn_out,
  output logic                                 out_dir_out,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [tfhcg_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tfhcg_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int W = tfhcg_pkg::CFG_W;

  tfhcg_pkg::gate_state_t st_r, st_nxt;
  logic [W-1:0]  tier_small_r, tier_medium_r, tier_large_r, max_record_r;
  logic          func_r, valid_r, rdok_r, dir_r;
  logic [5:0]    slot_r;
  logic [31:0]   ip_r, len_r;
  logic [15:0]   port_r;
  logic [63:0]   conn_r;
  logic [47:0]   head_r;
  logic [1:0]    tier_r;
  logic          trunc_r;
  logic [W-1:0]  n_r;
  logic          http_r;
  logic [2:0]    verdict_r;
  logic [1:0]    otier_r;
  logic          otrunc_r;
  logic [W-1:0]  copy_r;
  logic [63:0]   oconn_r;
  logic          odir_r;

  logic          accept;
  tfhcg_pkg::tgt_cmd_t   tgt_cmd;
  tfhcg_pkg::tgt_rsp_t   tgt_rsp;
  tfhcg_pkg::cache_cmd_t cache_cmd;
  tfhcg_pkg::cache_rsp_t cache_rsp;
  logic          res_load;
  logic [2:0]    res_verdict;
  logic [1:0]    res_tier;
  logic          res_trunc;
  logic [W-1:0]  res_copy;
  logic          res_echo;
  logic [1:0]    tier_c;
  logic [W-1:0]  cap_c;
  logic          trunc_c;
  logic [W-1:0]  n_c;

  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  // tier pick and copy length clamp
  always_comb begin
    if (len_r <= {9'd0, tier_small_r}) begin
      tier_c = tfhcg_pkg::TIER_SMALL;
      cap_c  = tier_small_r;
    end else if (len_r <= {9'd0, tier_medium_r}) begin
      tier_c = tfhcg_pkg::TIER_MEDIUM;
      cap_c  = tier_medium_r;
    end else if (len_r <= {9'd0, tier_large_r}) begin
      tier_c = tfhcg_pkg::TIER_LARGE;
      cap_c  = tier_large_r;
    end else begin
      tier_c = tfhcg_pkg::TIER_MAX;
      cap_c  = max_record_r;
    end
    trunc_c = len_r > {9'd0, cap_c};
    n_c     = trunc_c ? cap_c : len_r[W-1:0];
  end

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      tfhcg_pkg::ST_IDLE:  if (accept) st_nxt = tfhcg_pkg::ST_EVAL;
      tfhcg_pkg::ST_EVAL:  st_nxt = func_r ? tfhcg_pkg::ST_TGT : tfhcg_pkg::ST_OUT;
      tfhcg_pkg::ST_TGT: begin
        if (tgt_rsp.done) begin
          if (tgt_rsp.match && (len_r != 32'd0) && rdok_r) begin
            st_nxt = tfhcg_pkg::ST_CACHE;
          end else begin
            st_nxt = tfhcg_pkg::ST_OUT;
          end
        end
      end
      tfhcg_pkg::ST_CACHE: if (cache_rsp.done) st_nxt = tfhcg_pkg::ST_OUT;
      tfhcg_pkg::ST_OUT:   st_nxt = tfhcg_pkg::ST_IDLE;
      default:             st_nxt = tfhcg_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    busy        = (st_r != tfhcg_pkg::ST_IDLE);
    out_valid   = (st_r == tfhcg_pkg::ST_OUT);
    tgt_cmd     = '{wr: 1'b0, srch: 1'b0};
    cache_cmd   = '{start: 1'b0, http_ok: http_r};
    res_load    = 1'b0;
    res_verdict = tfhcg_pkg::V_WRITTEN;
    res_tier    = tfhcg_pkg::TIER_SMALL;
    res_trunc   = 1'b0;
    res_copy    = '0;
    res_echo    = 1'b1;
    case (st_r)
      tfhcg_pkg::ST_EVAL: begin
        if (func_r) begin
          tgt_cmd.srch = 1'b1;
        end else begin
          tgt_cmd.wr = 1'b1;
          res_load   = 1'b1;
          res_echo   = 1'b0;
        end
      end
      tfhcg_pkg::ST_TGT: begin
        if (tgt_rsp.done) begin
          if (!tgt_rsp.match) begin
            res_load    = 1'b1;
            res_verdict = tfhcg_pkg::V_NOT_TARGET;
          end else if (len_r == 32'd0) begin
            res_load    = 1'b1;
            res_verdict = tfhcg_pkg::V_EMPTY;
          end else if (!rdok_r) begin
            res_load    = 1'b1;
            res_verdict = tfhcg_pkg::V_READ_FAIL;
            res_tier    = tier_r;
            res_trunc   = trunc_r;
          end else begin
            cache_cmd.start = 1'b1;
          end
        end
      end
      tfhcg_pkg::ST_CACHE: begin
        if (cache_rsp.done) begin
          res_load    = 1'b1;
          res_verdict = cache_rsp.emit ? tfhcg_pkg::V_EMITTED : tfhcg_pkg::V_NOT_HTTP;
          res_tier    = tier_r;
          res_trunc   = trunc_r;
          res_copy    = cache_rsp.emit ? n_r : '0;
        end
      end
      default: begin
      end
    endcase
  end

  // control state and config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r          <= tfhcg_pkg::ST_IDLE;
      tier_small_r  <= tfhcg_pkg::RST_TIER_SMALL;
      tier_medium_r <= tfhcg_pkg::RST_TIER_MEDIUM;
      tier_large_r  <= tfhcg_pkg::RST_TIER_LARGE;
      max_record_r  <= tfhcg_pkg::RST_MAX_RECORD;
    end else begin
      st_r <= st_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          tfhcg_pkg::REG_TIER_SMALL:  tier_small_r  <= cfg_data[W-1:0];
          tfhcg_pkg::REG_TIER_MEDIUM: tier_medium_r <= cfg_data[W-1:0];
          tfhcg_pkg::REG_TIER_LARGE:  tier_large_r  <= cfg_data[W-1:0];
          tfhcg_pkg::REG_MAX_RECORD:  max_record_r  <= cfg_data[W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // item word, derived fields and result word
  always_ff @(posedge clk) begin
    if (accept) begin
      func_r  <= in_func;
      slot_r  <= in_slot;
      valid_r <= in_entry_valid;
      ip_r    <= in_dest_ip;
      port_r  <= in_dest_port;
      conn_r  <= in_conn_id;
      len_r   <= in_payload_len;
      head_r  <= in_head_bytes;
      rdok_r  <= in_read_ok;
      dir_r   <= in_direction;
    end
    if (st_r == tfhcg_pkg::ST_EVAL) begin
      tier_r  <= tier_c;
      trunc_r <= trunc_c;
      n_r     <= n_c;
      http_r  <= tfhcg_pkg::looks_http(head_r, n_c);
    end
    if (res_load) begin
      verdict_r <= res_verdict;
      otier_r   <= res_tier;
      otrunc_r  <= res_trunc;
      copy_r    <= res_copy;
      oconn_r   <= res_echo ? conn_r : 64'd0;
      odir_r    <= res_echo && dir_r;
    end
  end

  assign out_verdict   = verdict_r;
  assign out_tier      = otier_r;
  assign out_truncated = otrunc_r;
  assign out_cap_len   = copy_r;
  assign out_conn_out  = oconn_r;
  assign out_dir_out   = odir_r;

  tfhcg_tgt_table u_tgt (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (tgt_cmd),
    .wr_slot (slot_r),
    .wr_live (valid_r),
    .ip      (ip_r),
    .port    (port_r),
    .rsp     (tgt_rsp)
  );

  tfhcg_conn_cache u_cache (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cache_cmd),
    .key   (conn_r),
    .rsp   (cache_rsp)
  );

  `TFHCG_ASSERT_NXT(a_accept_busy, accept, busy)
  `TFHCG_ASSERT_NXT(a_out_then_idle, out_valid, !busy && !out_valid)
  `TFHCG_ASSERT_IMP(a_cap_only_emit, out_valid && (verdict_r != 3'd5), copy_r == '0)

endmodule

>>> rtl/tfhcg_tgt_table.sv
// destination target table: slot memory, live bits and a matching sweep
// depends on tfhcg_pkg
module tfhcg_tgt_table (
  input  logic                           clk,
  input  logic                           rst_n,
  input  tfhcg_pkg::tgt_cmd_t            cmd,
  input  logic [tfhcg_pkg::TGT_AW-1:0]   wr_slot,
  input  logic                           wr_live,
  input  logic [31:0]                    ip,
  input  logic [15:0]                    port,
  output tfhcg_pkg::tgt_rsp_t            rsp
);

  localparam int CW = tfhcg_pkg::TGT_AW + 1;

  logic [47:0]                  tmem [tfhcg_pkg::TGT_ENTRIES];
  logic [47:0]                  rdata_r;
  logic [tfhcg_pkg::TGT_ENTRIES-1:0] live_r;
  logic                         active_r;
  logic [CW-1:0]                rd_cnt_r;
  logic                         chk_vld_r;
  logic [tfhcg_pkg::TGT_AW-1:0] chk_idx_r;
  logic                         match_r;
  logic                         rd_en;
  logic                         hit_now;
  logic                         done;

  assign rd_en   = active_r && (rd_cnt_r < CW'(tfhcg_pkg::TGT_ENTRIES));
  // zero in a stored field matches anything
  assign hit_now = chk_vld_r && live_r[chk_idx_r] &&
                   ((rdata_r[47:16] == ip) || (rdata_r[47:16] == 32'd0)) &&
                   ((rdata_r[15:0] == port) || (rdata_r[15:0] == 16'd0));
  assign done    = active_r && !rd_en && !chk_vld_r;
  assign rsp     = '{done: done, match: match_r};

  // slot memory
  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      tmem[wr_slot] <= {ip, port};
    end
    if (rd_en) begin
      rdata_r <= tmem[rd_cnt_r[tfhcg_pkg::TGT_AW-1:0]];
    end
  end

  // live bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r <= '0;
    end else if (cmd.wr) begin
      live_r[wr_slot] <= wr_live;
    end
  end

  // sweep over all slots, one read a cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r  <= 1'b0;
      rd_cnt_r  <= '0;
      chk_vld_r <= 1'b0;
      chk_idx_r <= '0;
      match_r   <= 1'b0;
    end else if (cmd.srch) begin
      active_r  <= 1'b1;
      rd_cnt_r  <= '0;
      chk_vld_r <= 1'b0;
      match_r   <= 1'b0;
    end else begin
      chk_vld_r <= rd_en;
      chk_idx_r <= rd_cnt_r[tfhcg_pkg::TGT_AW-1:0];
      if (rd_en) begin
        rd_cnt_r <= rd_cnt_r + CW'(1);
      end
      if (hit_now) begin
        match_r <= 1'b1;
      end
      if (done) begin
        active_r <= 1'b0;
      end
    end
  end

endmodule

>>> rtl/tfhcg_conn_cache.sv
// lru cache of http connections: tag and age memory, probe and update sweeps
// depends on tfhcg_pkg and the assertion macro header
`include "tcp_flow_http_capture_gate_macros.svh"

module tfhcg_conn_cache (
  input  logic                          clk,
  input  logic                          rst_n,
  input  tfhcg_pkg::cache_cmd_t         cmd,
  input  logic [tfhcg_pkg::TAG_W-1:0]   key,
  output tfhcg_pkg::cache_rsp_t         rsp
);

  localparam int AW = tfhcg_pkg::CONN_AW;
  localparam int CW = tfhcg_pkg::CONN_CW;
  localparam int GW = tfhcg_pkg::AGE_W;
  localparam int DW = tfhcg_pkg::TAG_W + GW;

  // live entries are always indexes 0 to fill-1
  logic [DW-1:0]   cmem [tfhcg_pkg::CONN_ENTRIES];
  logic [DW-1:0]   rdata_r;
  tfhcg_pkg::cache_state_t cst_r, cst_nxt;
  logic [CW-1:0]   fill_r;
  logic [CW-1:0]   rd_cnt_r;
  logic [CW-1:0]   lim_r;
  logic            chk_vld_r;
  logic [AW-1:0]   chk_idx_r;
  logic            http_r;
  logic            hit_r;
  logic [AW-1:0]   hit_idx_r;
  logic [GW-1:0]   hit_age_r;
  logic [GW-1:0]   max_age_r;
  logic [AW-1:0]   max_idx_r;
  logic [AW-1:0]   e_r;
  logic [GW-1:0]   a_r;
  logic            ainf_r;
  logic            rd_en;
  logic            sweep_end;
  logic            done;
  logic            wr_en;
  logic [DW-1:0]   wdata;
  logic [tfhcg_pkg::TAG_W-1:0] rtag;
  logic [GW-1:0]   rage;

  assign rtag = rdata_r[DW-1:GW];
  assign rage = rdata_r[GW-1:0];

  // next state
  always_comb begin
    cst_nxt = cst_r;
    case (cst_r)
      tfhcg_pkg::CS_IDLE:  if (cmd.start) cst_nxt = tfhcg_pkg::CS_PROBE;
      tfhcg_pkg::CS_PROBE: if (sweep_end) cst_nxt = tfhcg_pkg::CS_DEC;
      tfhcg_pkg::CS_DEC:   cst_nxt = (hit_r || http_r) ? tfhcg_pkg::CS_UPD : tfhcg_pkg::CS_IDLE;
      tfhcg_pkg::CS_UPD:   if (sweep_end) cst_nxt = tfhcg_pkg::CS_IDLE;
      default:             cst_nxt = tfhcg_pkg::CS_IDLE;
    endcase
  end

  // sweep control, write back and response
  always_comb begin
    rd_en     = ((cst_r == tfhcg_pkg::CS_PROBE) || (cst_r == tfhcg_pkg::CS_UPD)) &&
                (rd_cnt_r < lim_r);
    sweep_end = !rd_en && !chk_vld_r;
    done      = ((cst_r == tfhcg_pkg::CS_DEC) && !(hit_r || http_r)) ||
                ((cst_r == tfhcg_pkg::CS_UPD) && sweep_end);
    wr_en     = 1'b0;
    wdata     = rdata_r;
    if ((cst_r == tfhcg_pkg::CS_UPD) && chk_vld_r) begin
      if (chk_idx_r == e_r) begin
        wr_en = 1'b1;
        wdata = {key, GW'(0)};
      end else if (ainf_r || (rage < a_r)) begin
        wr_en = 1'b1;
        wdata = {rtag, rage + GW'(1)};
      end
    end
  end

  assign rsp = '{done: done, emit: hit_r || http_r};

  // tag and age memory, read and write back never hit the same entry at once
  always_ff @(posedge clk) begin
    if (wr_en) begin
      cmem[chk_idx_r] <= wdata;
    end
    if (rd_en) begin
      rdata_r <= cmem[rd_cnt_r[AW-1:0]];
    end
  end

  // state and sweep registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cst_r     <= tfhcg_pkg::CS_IDLE;
      fill_r    <= '0;
      rd_cnt_r  <= '0;
      lim_r     <= '0;
      chk_vld_r <= 1'b0;
      chk_idx_r <= '0;
      http_r    <= 1'b0;
      hit_r     <= 1'b0;
    end else begin
      cst_r     <= cst_nxt;
      chk_vld_r <= rd_en;
      chk_idx_r <= rd_cnt_r[AW-1:0];
      if (rd_en) begin
        rd_cnt_r <= rd_cnt_r + CW'(1);
      end
      case (cst_r)
        tfhcg_pkg::CS_IDLE: begin
          if (cmd.start) begin
            rd_cnt_r  <= '0;
            lim_r     <= fill_r;
            http_r    <= cmd.http_ok;
            hit_r     <= 1'b0;
            max_age_r <= '0;
            max_idx_r <= '0;
          end
        end
        tfhcg_pkg::CS_PROBE: begin
          if (chk_vld_r) begin
            if (!hit_r && (rtag == key)) begin
              hit_r     <= 1'b1;
              hit_idx_r <= chk_idx_r;
              hit_age_r <= rage;
            end
            if (rage > max_age_r) begin
              max_age_r <= rage;
              max_idx_r <= chk_idx_r;
            end
          end
        end
        tfhcg_pkg::CS_DEC: begin
          rd_cnt_r <= '0;
          lim_r    <= fill_r;
          ainf_r   <= 1'b0;
          if (hit_r) begin
            e_r <= hit_idx_r;
            a_r <= hit_age_r;
          end else if (fill_r < CW'(tfhcg_pkg::CONN_ENTRIES)) begin
            // new entry at lowest free index, every other live entry ages by one
            e_r    <= fill_r[AW-1:0];
            a_r    <= '0;
            ainf_r <= 1'b1;
            lim_r  <= fill_r + CW'(1);
            if (http_r) begin
              fill_r <= fill_r + CW'(1);
            end
          end else begin
            // full: evict the least recent entry
            e_r <= max_idx_r;
            a_r <= max_age_r;
          end
        end
        default: begin
        end
      endcase
    end
  end

  `TFHCG_ASSERT_IMP(a_fill_bound, 1'b1, fill_r <= CW'(tfhcg_pkg::CONN_ENTRIES))
  `TFHCG_ASSERT_IMP(a_wr_only_upd, wr_en, cst_r == tfhcg_pkg::CS_UPD)
  `TFHCG_ASSERT_NXT(a_done_idle, done, cst_r == tfhcg_pkg::CS_IDLE)

endmodule
